/* rtl/core/hsl_pkg.sv */
// Shared widths, constants and pipeline control types for the HSL to RGB converter.
package hsl_pkg;

   localparam int HueWidth     = 16;
   localparam int FracWidth    = 17;   // saturation and lightness, Q16 up to 1.99998
   localparam int ChanWidth    = 8;
   localparam int NumChans     = 3;

   localparam int QShift       = 16;
   localparam int QOne         = 65536;
   localparam int QHalf        = 32768;
   localparam int QThird       = 21845;
   localparam int QTwoThirds   = 43691;
   localparam int GreyLimit    = 655;
   localparam int ChanMax      = 255;

   localparam int ProdWidth    = 35;   // lightness * (1.0 + saturation)
   localparam int ValWidth     = 22;   // var1 and the var2 - var1 spread, signed
   localparam int MultWidth    = 17;   // hue ramp factor, 0 .. 65538
   localparam int MulOutWidth  = ValWidth + MultWidth + 1;
   localparam int CoefWidth    = 23;

   localparam int NumStages    = 5;

   // Channel order within the packed ramp-factor bus
   localparam int ChanRed      = 0;
   localparam int ChanGreen    = 1;
   localparam int ChanBlue     = 2;

   typedef struct packed {
      logic [NumStages-1:0] load;   // stage register takes a new beat this cycle
   } hsl_pipe_ctl_type;

endpackage

/* rtl/core/hsl_req_if.sv */
// Request channel: one HSL colour per beat.
interface hsl_req_if import hsl_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [HueWidth-1:0]  hue;
   logic [FracWidth-1:0] saturation;
   logic [FracWidth-1:0] lightness;

   modport source (output valid, hue, saturation, lightness, input ready);
   modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

/* rtl/core/hsl_rsp_if.sv */
// Response channel: one RGB colour per beat.
interface hsl_rsp_if import hsl_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ChanWidth-1:0] red;
   logic [ChanWidth-1:0] green;
   logic [ChanWidth-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

/* rtl/core/hsl_pipe_ctl.sv */
// Valid tracking and per-stage load enables for the converter pipeline.
module hsl_pipe_ctl import hsl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output hsl_pipe_ctl_type ctl
);

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] load;

   // A stage loads when it is empty or its contents move on
   always_comb begin
      load[NumStages-1] = !valid_ff[NumStages-1] || out_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load[0]) begin
         valid_in[0] = in_valid;
      end
      for (int k = 1; k < NumStages; k++) begin
         if (load[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = load[0];
   assign out_valid = valid_ff[NumStages-1];
   assign ctl.load  = load;

   a_accept_fills_first : assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("accepted beat did not enter first stage");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (&valid_ff))
      else $error("input stalled with a bubble in the pipeline");

   a_occupancy : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(valid_ff) == $past($countones(valid_ff))
         + $past(in_valid && in_ready) - $past(out_valid && out_ready)))
      else $error("beat lost or duplicated in pipeline");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

endmodule

/* rtl/core/hsl_prep.sv */
// Stages one and two: var1/var2 and the three hue ramp factors.
module hsl_prep import hsl_pkg::*; (
   input  logic                              clock,
   input  hsl_pipe_ctl_type                  ctl,
   input  logic [HueWidth-1:0]               hue,
   input  logic [FracWidth-1:0]              saturation,
   input  logic [FracWidth-1:0]              lightness,
   output logic signed [ValWidth-1:0]        var1,
   output logic signed [ValWidth-1:0]        spread,
   output logic [NumChans-1:0][MultWidth-1:0] mult
);

   // Ramp factor for a wrapped hue; flat var2 is a factor of one, flat var1 zero
   function automatic logic [MultWidth-1:0] ramp_factor(input logic [HueWidth-1:0] h);
      logic [HueWidth+3:0] h6;
      logic [HueWidth+3:0] h2;
      logic [HueWidth+3:0] h3;
      logic [HueWidth+3:0] down;
      begin
         h6   = (HueWidth+4)'(h) * (HueWidth+4)'(6);
         h2   = (HueWidth+4)'(h) << 1;
         h3   = (HueWidth+4)'(h) * (HueWidth+4)'(3);
         down = ((HueWidth+4)'(QTwoThirds) - (HueWidth+4)'(h)) * (HueWidth+4)'(6);
         if (h6 < (HueWidth+4)'(QOne)) begin
            ramp_factor = h6[MultWidth-1:0];
         end else if (h2 < (HueWidth+4)'(QOne)) begin
            ramp_factor = MultWidth'(QOne);
         end else if (h3 < (HueWidth+4)'(2 * QOne)) begin
            ramp_factor = down[MultWidth-1:0];
         end else begin
            ramp_factor = '0;
         end
      end
   endfunction

   // stage 1
   logic [ProdWidth-1:0]               prod_ff,  prod_in;
   logic [FracWidth-1:0]               light_ff;
   logic [FracWidth-1:0]               sat_ff;
   logic                               grey_ff,  grey_in;
   logic                               dark_ff,  dark_in;
   logic [NumChans-1:0][MultWidth-1:0] mult1_ff, mult1_in;
   logic [HueWidth-1:0]                hue_red, hue_blue;

   assign hue_red  = hue + HueWidth'(QThird);
   assign hue_blue = hue + HueWidth'(QOne - QThird);

   always_comb begin
      grey_in = saturation < FracWidth'(GreyLimit);
      dark_in = lightness  < FracWidth'(QHalf);
      if (dark_in) begin
         prod_in = ProdWidth'(lightness) * (ProdWidth'(saturation) + ProdWidth'(QOne));
      end else begin
         prod_in = ProdWidth'(lightness) * ProdWidth'(saturation);
      end
      mult1_in[ChanRed]   = ramp_factor(hue_red);
      mult1_in[ChanGreen] = ramp_factor(hue);
      mult1_in[ChanBlue]  = ramp_factor(hue_blue);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         prod_ff  <= prod_in;
         light_ff <= lightness;
         sat_ff   <= saturation;
         grey_ff  <= grey_in;
         dark_ff  <= dark_in;
         mult1_ff <= mult1_in;
      end
   end

   // stage 2
   logic signed [ValWidth-1:0]         var1_ff,   var1_in;
   logic signed [ValWidth-1:0]         spread_ff, spread_in;
   logic [NumChans-1:0][MultWidth-1:0] mult2_ff;
   logic signed [ValWidth-1:0]         prod_q;
   logic signed [ValWidth-1:0]         light_s;
   logic signed [ValWidth-1:0]         var2;

   always_comb begin
      prod_q  = signed'(ValWidth'(prod_ff >> QShift));
      light_s = signed'(ValWidth'(light_ff));
      if (dark_ff) begin
         var2 = prod_q;
      end else begin
         var2 = light_s + signed'(ValWidth'(sat_ff)) - prod_q;
      end
      if (grey_ff) begin
         // grey: every coefficient collapses to lightness
         var1_in   = light_s;
         spread_in = '0;
      end else begin
         var1_in   = (light_s <<< 1) - var2;
         spread_in = (var2 - light_s) <<< 1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         var1_ff   <= var1_in;
         spread_ff <= spread_in;
         mult2_ff  <= mult1_ff;
      end
   end

   assign var1   = var1_ff;
   assign spread = spread_ff;
   assign mult   = mult2_ff;

endmodule

/* rtl/core/hsl_chan.sv */
// Stages three to five for one channel: ramp product, coefficient, 8-bit scaling.
module hsl_chan import hsl_pkg::*; (
   input  logic                       clock,
   input  hsl_pipe_ctl_type           ctl,
   input  logic signed [ValWidth-1:0] var1,
   input  logic signed [ValWidth-1:0] spread,
   input  logic [MultWidth-1:0]       mult,
   output logic [ChanWidth-1:0]       level
);

   localparam int ScaleWidth = CoefWidth + 9;

   // stage 3
   logic signed [MulOutWidth-1:0] prod_ff,  prod_in;
   logic signed [ValWidth-1:0]    base_ff;

   assign prod_in = MulOutWidth'(spread) * signed'(MulOutWidth'(mult));

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         prod_ff <= prod_in;
         base_ff <= var1;
      end
   end

   // stage 4: arithmetic shift floors toward minus infinity
   logic signed [CoefWidth-1:0] coef_ff, coef_in;
   logic signed [MulOutWidth-1:0] prod_sh;

   assign prod_sh = prod_ff >>> QShift;
   assign coef_in = CoefWidth'(base_ff) + prod_sh[CoefWidth-1:0];

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         coef_ff <= coef_in;
      end
   end

   // stage 5: floor(255 * coef) in Q16, clamped
   logic [ChanWidth-1:0]  level_ff, level_in;
   logic [ScaleWidth-1:0] scaled;
   logic [ScaleWidth-1:0] whole;

   always_comb begin
      scaled = ScaleWidth'(unsigned'(coef_ff)) * ScaleWidth'(ChanMax);
      whole  = scaled >> QShift;
      if (coef_ff <= 0) begin
         level_in = '0;
      end else if (whole > ScaleWidth'(ChanMax)) begin
         level_in = ChanWidth'(ChanMax);
      end else begin
         level_in = whole[ChanWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

/* rtl/core/hsl_to_rgb_converter.sv */
// Top level: pipelined HSL to 8-bit RGB colour converter.
//
//   channel   dir  beat payload                         handshake
//   req_bus   in   hue[15:0] saturation[16:0]          valid/ready
//                  lightness[16:0] (Q16)
//   rsp_bus   out  red[7:0] green[7:0] blue[7:0]       valid/ready
//
// Five register stages; one beat a cycle is sustained while rsp_bus.ready
// stays high. The two multiplier stages (var2 product, ramp product) and the
// 255 scaling are each followed by a register. Synchronous reset empties the
// pipeline; payload is not reset.
// Each stage holds while the next is full and stalled, so bubbles are closed
// up and req_bus.ready drops only when all five stages are occupied.
module hsl_to_rgb_converter import hsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hsl_req_if.sink     req_bus,
   hsl_rsp_if.source   rsp_bus
);

   hsl_pipe_ctl_type                   ctl;
   logic signed [ValWidth-1:0]         var1;
   logic signed [ValWidth-1:0]         spread;
   logic [NumChans-1:0][MultWidth-1:0] mult;

   // valid bits and load enables for all stages
   hsl_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .ctl       (ctl)
   );

   // var1, var2 - var1 and per-channel hue ramp factors
   hsl_prep u_prep (
      .clock      (clock),
      .ctl        (ctl),
      .hue        (req_bus.hue),
      .saturation (req_bus.saturation),
      .lightness  (req_bus.lightness),
      .var1       (var1),
      .spread     (spread),
      .mult       (mult)
   );

   // red sits a third of a turn ahead, blue a third behind
   hsl_chan u_red (
      .clock  (clock),
      .ctl    (ctl),
      .var1   (var1),
      .spread (spread),
      .mult   (mult[ChanRed]),
      .level  (rsp_bus.red)
   );

   hsl_chan u_green (
      .clock  (clock),
      .ctl    (ctl),
      .var1   (var1),
      .spread (spread),
      .mult   (mult[ChanGreen]),
      .level  (rsp_bus.green)
   );

   hsl_chan u_blue (
      .clock  (clock),
      .ctl    (ctl),
      .var1   (var1),
      .spread (spread),
      .mult   (mult[ChanBlue]),
      .level  (rsp_bus.blue)
   );

endmodule

/* sim/hsl_rgb_scoreboard.sv */
// Scoreboard for the HSL to RGB converter: predicts each colour and checks the rsp beats.
module hsl_rgb_scoreboard import hsl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hsl_req_if          req_bus,
   hsl_rsp_if          rsp_bus,
   output int unsigned fault_count,
   output int unsigned pending_count
);

   localparam int ReportLimit = 10;

   typedef logic [NumChans-1:0][ChanWidth-1:0] rgb_type;

   rgb_type expected_rgb[$];

   // Q16 product, floored towards minus infinity
   function automatic longint q16_mul_floor(longint a, longint b);
      return (a * b) >>> QShift;
   endfunction

   // piecewise hue ramp between the low and high values
   function automatic longint ramp_coef(longint lo, longint hi, logic [HueWidth-1:0] vh);
      longint h;
      h = vh;
      if (6 * h < QOne)
         return lo + q16_mul_floor(hi - lo, 6 * h);
      if (2 * h < QOne)
         return hi;
      if (3 * h < 2 * QOne)
         return lo + q16_mul_floor(hi - lo, (QTwoThirds - h) * 6);
      return lo;
   endfunction

   function automatic logic [ChanWidth-1:0] channel_level(longint coef);
      longint v;
      if (coef <= 0)
         return '0;
      v = (coef * ChanMax) >>> QShift;
      if (v > ChanMax)
         v = ChanMax;
      return ChanWidth'(v);
   endfunction

   function automatic rgb_type predict_rgb(logic [HueWidth-1:0] hue,
                                           logic [FracWidth-1:0] sat,
                                           logic [FracWidth-1:0] lit);
      longint  s, l, hi, lo;
      rgb_type rgb;
      s = sat;
      l = lit;
      if (s < GreyLimit) begin
         rgb[ChanRed]   = channel_level(l);
         rgb[ChanGreen] = channel_level(l);
         rgb[ChanBlue]  = channel_level(l);
         return rgb;
      end
      if (l < QHalf)
         hi = q16_mul_floor(l, QOne + s);
      else
         hi = l + s - q16_mul_floor(s, l);
      lo = 2 * l - hi;
      // hue offsets wrap modulo one turn at 16 bits
      rgb[ChanRed]   = channel_level(ramp_coef(lo, hi, hue + HueWidth'(QThird)));
      rgb[ChanGreen] = channel_level(ramp_coef(lo, hi, hue));
      rgb[ChanBlue]  = channel_level(ramp_coef(lo, hi, hue + HueWidth'(QOne - QThird)));
      return rgb;
   endfunction

   function automatic string chan_label(int c);
      case (c)
         ChanRed:   return "red";
         ChanGreen: return "green";
         default:   return "blue";
      endcase
   endfunction

   always @(posedge clock) begin
      rgb_type want;
      rgb_type got;
      bit      wrong;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got[ChanRed]   = rsp_bus.red;
            got[ChanGreen] = rsp_bus.green;
            got[ChanBlue]  = rsp_bus.blue;
            if (expected_rgb.size() == 0) begin
               fault_count++;
               if (fault_count <= ReportLimit)
                  $display("%0t: rsp beat with nothing outstanding, got %0d %0d %0d",
                           $realtime, got[ChanRed], got[ChanGreen], got[ChanBlue]);
            end else begin
               want  = expected_rgb.pop_front();
               wrong = 1'b0;
               for (int c = 0; c < NumChans; c++) begin
                  if (got[c] !== want[c]) begin
                     wrong = 1'b1;
                     if (fault_count < ReportLimit)
                        $display("%0t: %s expected %0d got %0d", $realtime, chan_label(c),
                                 want[c], got[c]);
                  end
               end
               if (wrong)
                  fault_count++;
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_rgb.push_back(predict_rgb(req_bus.hue, req_bus.saturation,
                                               req_bus.lightness));
      end
      pending_count <= expected_rgb.size();
   end

endmodule

/* sim/hsl_to_rgb_converter_tb.sv */
// Testbench top for the HSL to RGB converter: stimulus, back-pressure and verdict.
module hsl_to_rgb_converter_tb import hsl_pkg::*;;

   localparam int RandomBeats = 1950;
   localparam int SteadyBeats = 250;      // closing stretch with no idling either side
   localparam int PhaseBeats  = 150;      // idle density is redrawn this often
   localparam int StallLimit  = 2000;     // cycles with no beat on either channel
   localparam int DrainCycles = 4 * NumStages;

   localparam logic [FracWidth-1:0] FracMax = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        steady = 1'b0;            // set for the closing stretch
   int          idle_pct = 25;            // chance of an idle burst per beat, in percent
   int unsigned fault_count;
   int unsigned pending_count;
   int unsigned quiet_cycles = 0;

   hsl_req_if req_bus ();
   hsl_rsp_if rsp_bus ();

   hsl_to_rgb_converter dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   hsl_rgb_scoreboard scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   always #6 clock = ~clock;

   // Watchdog: a correct run never goes long without a beat, even with both
   // sides in their longest bursts and the pipeline refilling.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Result side back-pressure: ready drops in random bursts.
   // Changes only at the falling edge, once per step.
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0)
            hold--;
         else if (!steady && $urandom_range(99) < idle_pct)
            hold = $urandom_range(5, 1);
         rsp_bus.ready <= (hold == 0);
      end
   end

   // Present one colour and hold it until the block takes it. Returns at the
   // falling edge after acceptance, so valid may stay high for the next beat
   // without being dropped in between.
   task automatic send_colour(input logic [HueWidth-1:0] h, input logic [FracWidth-1:0] s,
                              input logic [FracWidth-1:0] l);
      req_bus.valid      <= 1'b1;
      req_bus.hue        <= h;
      req_bus.saturation <= s;
      req_bus.lightness  <= l;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Optional sender gap; the payload carries junk while valid is low.
   task automatic maybe_pause();
      if (!steady && $urandom_range(99) < idle_pct) begin
         req_bus.valid      <= 1'b0;
         req_bus.hue        <= HueWidth'($urandom);
         req_bus.saturation <= FracWidth'($urandom);
         req_bus.lightness  <= FracWidth'($urandom);
         repeat ($urandom_range(5, 1)) @(negedge clock);
      end
   endtask

   // Random colour, weighted towards the interesting regions: the grey
   // threshold, the lightness midpoint, the ramp corners in hue, and the
   // over-range values above 1.0 in saturation and lightness.
   task automatic random_colour(output logic [HueWidth-1:0] h, output logic [FracWidth-1:0] s,
                                output logic [FracWidth-1:0] l);
      int pick;
      int corner;
      pick = $urandom_range(99);
      if (pick < 15) begin
         case ($urandom_range(6))
            0: corner = 0;
            1: corner = 10922;     // end of rising ramp
            2: corner = QThird;    // blue wraps to zero
            3: corner = 32767;     // end of plateau
            4: corner = QTwoThirds - 1;
            5: corner = QTwoThirds; // red wraps to zero
            default: corner = 54613;
         endcase
         h = HueWidth'(corner + $urandom_range(4) - 2);
      end else begin
         h = HueWidth'($urandom);
      end

      pick = $urandom_range(99);
      if (pick < 10)
         s = FracWidth'($urandom_range(GreyLimit - 1, 0));
      else if (pick < 15)
         s = FracWidth'($urandom_range(GreyLimit + 2, GreyLimit - 2));
      else if (pick < 75)
         s = FracWidth'($urandom_range(QOne, GreyLimit));
      else
         s = FracWidth'($urandom_range(int'(FracMax), QOne + 1));

      pick = $urandom_range(99);
      if (pick < 10)
         l = FracWidth'($urandom_range(QHalf + 3, QHalf - 4));
      else if (pick < 70)
         l = FracWidth'($urandom_range(QOne, 0));
      else if (pick < 80)
         l = FracWidth'($urandom_range(2000, 0));
      else
         l = FracWidth'($urandom_range(int'(FracMax), QOne + 1));
   endtask

   initial begin
      logic [HueWidth-1:0]  h;
      logic [FracWidth-1:0] s;
      logic [FracWidth-1:0] l;
      req_bus.valid      = 1'b0;
      req_bus.hue        = '0;
      req_bus.saturation = '0;
      req_bus.lightness  = '0;

      // single reset at the start, synchronous
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: greys either side of the threshold, primaries, ramp corners
      // and hue wrap points, lightness either side of one half, over-range
      // saturation and lightness, a negative low value and a clamped grey.
      send_colour(16'd0,     17'd0,      17'd0);       maybe_pause();
      send_colour(16'd0,     17'd0,      17'd65536);   maybe_pause();
      send_colour(16'd0,     17'd654,    17'd32768);   maybe_pause();
      send_colour(16'd0,     17'd655,    17'd32768);   maybe_pause();
      send_colour(16'd0,     17'd65536,  17'd32768);   maybe_pause();
      send_colour(16'd21845, 17'd65536,  17'd32768);   maybe_pause();
      send_colour(16'd43691, 17'd65536,  17'd32768);   maybe_pause();
      send_colour(16'hFFFF,  FracMax,    FracMax);     maybe_pause();
      send_colour(16'd10922, 17'd65536,  17'd32767);   maybe_pause();
      send_colour(16'd10923, 17'd65536,  17'd32768);   maybe_pause();
      send_colour(16'd32767, 17'd65536,  17'd16384);   maybe_pause();
      send_colour(16'd32768, 17'd65536,  17'd49152);   maybe_pause();
      send_colour(16'd43690, 17'd90000,  17'd20000);   maybe_pause();
      send_colour(16'd54613, 17'd65536,  17'd32768);   maybe_pause();
      send_colour(16'd5000,  FracMax,    17'd10000);   maybe_pause();
      send_colour(16'd0,     17'd0,      FracMax);     maybe_pause();
      send_colour(16'd30000, FracMax,    17'd65536);   maybe_pause();
      send_colour(16'd12345, 17'd65536,  17'd0);       maybe_pause();
      send_colour(16'd0,     FracMax,    17'd32767);   maybe_pause();
      send_colour(16'd60000, 17'd40000,  17'd98304);   maybe_pause();
      send_colour(16'hFFFF,  17'd655,    17'd65535);   maybe_pause();

      // Random part in phases of differing idle density, quiet at the end
      for (int b = 0; b < RandomBeats; b++) begin
         if (b % PhaseBeats == 0) begin
            case ($urandom_range(3))
               0: idle_pct = 0;
               1: idle_pct = 10;
               2: idle_pct = 30;
               default: idle_pct = 60;
            endcase
         end
         if (b == RandomBeats - SteadyBeats)
            steady = 1'b1;
         random_colour(h, s, l);
         send_colour(h, s, l);
         maybe_pause();
      end
      req_bus.valid <= 1'b0;

      // drain: the watchdog bounds this wait
      while (pending_count != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fault_count == 0 && pending_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/core/hsl_pkg.sv
rtl/core/hsl_req_if.sv
rtl/core/hsl_rsp_if.sv
rtl/core/hsl_pipe_ctl.sv
rtl/core/hsl_prep.sv
rtl/core/hsl_chan.sv
rtl/core/hsl_to_rgb_converter.sv
sim/hsl_rgb_scoreboard.sv
sim/hsl_to_rgb_converter_tb.sv
